// ----- rtl/fssa_pkg.sv -----
// ----------------------------------------------------------------------------
// fssa_pkg
// Shared types and codes for the fit-strategy slot allocator.
// ----------------------------------------------------------------------------
package fssa_pkg;

  // Tag that marks a free slot (the space character).
  localparam logic [7:0] FREE_TAG = 8'd32;

  // Item kinds.
  localparam logic [1:0] KIND_PRESET = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_ALLOC  = 2'd2;

  // Placement strategies; the unused code behaves as first fit.
  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_BEST  = 2'd1;
  localparam logic [1:0] STRAT_WORST = 2'd2;

  // Result status codes.
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_NOSPACE = 1'b1;

  // Payload of one request item.
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] slot_address;
    logic [7:0] tag_value;
    logic [7:0] request_size;
    logic [1:0] strategy;
  } req_t;

  // Payload of one result item.
  typedef struct packed {
    logic       status;
    logic [6:0] placed_start;
    logic [7:0] read_tag;
  } rsp_t;

endpackage

// ----- rtl/fssa_req_if.sv -----
// ----------------------------------------------------------------------------
// fssa_req_if
// Valid/ready channel that carries request items into the allocator.
// ----------------------------------------------------------------------------
interface fssa_req_if;
  logic            valid;
  logic            ready;
  fssa_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/fssa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fssa_rsp_if
// Valid/ready channel that carries result items out of the allocator.
// ----------------------------------------------------------------------------
interface fssa_rsp_if;
  logic            valid;
  logic            ready;
  fssa_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/fssa_mem.sv -----
// ----------------------------------------------------------------------------
// fssa_mem
// Slot tag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fssa_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fssa_ctrl.sv -----
// ----------------------------------------------------------------------------
// fssa_ctrl
// Sequencer: clears the store, serves preset and read items, and runs the
// hole scan and run fill of an allocation against the slot tag store.
// ----------------------------------------------------------------------------
module fssa_ctrl #(
  parameter int SLOTS = 128,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  fssa_req_if.sink       req,
  output logic           res_valid_o,
  output fssa_pkg::rsp_t res_o,
  input  logic           res_ready_i,
  output logic           mem_we_o,
  output logic [AW-1:0]  mem_waddr_o,
  output logic [7:0]     mem_wdata_o,
  output logic           mem_re_o,
  output logic [AW-1:0]  mem_raddr_o,
  input  logic [7:0]     mem_rdata_i
);

  // Counter and length width (holds SLOTS itself) and compare width.
  localparam int CW = $clog2(SLOTS + 1);
  localparam int GW = (CW > 8) ? CW : 8;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]     state_q, state_d;
  logic [CW-1:0]  iss_q, iss_d;
  logic           pv_q, pv_d;
  logic [CW-1:0]  pidx_q, pidx_d;
  logic           in_run_q, in_run_d;
  logic [AW-1:0]  run_start_q, run_start_d;
  logic [CW-1:0]  run_len_q, run_len_d;
  logic           have_q, have_d;
  logic [AW-1:0]  pick_start_q, pick_start_d;
  logic [CW-1:0]  pick_len_q, pick_len_d;
  logic [7:0]     need_q, need_d;
  logic [1:0]     strat_q, strat_d;
  logic [7:0]     tag_q, tag_d;
  logic [7:0]     fill_cnt_q, fill_cnt_d;
  logic           rd_ok_q, rd_ok_d;
  fssa_pkg::rsp_t pend_q, pend_d;

  logic           req_fire;
  logic           addr_ok;
  logic           slot_free;
  logic           slot_last;
  logic [AW-1:0]  new_start;
  logic [CW-1:0]  new_len;
  logic           cand_v;
  logic [AW-1:0]  cand_start;
  logic [CW-1:0]  cand_len;
  logic           cand_fits;
  logic           cand_take;

  assign req.ready   = (state_q == ST_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign addr_ok     = (32'(req.data.slot_address) < SLOTS);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = pend_q;

  // Hole tracking on the slot that came back from the store this cycle.
  always_comb begin
    slot_free  = (mem_rdata_i == fssa_pkg::FREE_TAG);
    slot_last  = (pidx_q == CW'(SLOTS - 1));
    new_start  = in_run_q ? run_start_q : pidx_q[AW-1:0];
    new_len    = in_run_q ? (run_len_q + CW'(1)) : CW'(1);
    cand_v     = pv_q && ((in_run_q && !slot_free) || (slot_free && slot_last));
    cand_start = slot_free ? new_start : run_start_q;
    cand_len   = slot_free ? new_len : run_len_q;
    cand_fits  = (GW'(cand_len) >= GW'(need_q));
    cand_take  = cand_v && cand_fits &&
                 (!have_q ||
                  ((strat_q == fssa_pkg::STRAT_BEST)  && (cand_len < pick_len_q)) ||
                  ((strat_q == fssa_pkg::STRAT_WORST) && (cand_len > pick_len_q)));
  end

  // Sequencer and store access.
  always_comb begin
    state_d      = state_q;
    iss_d        = iss_q;
    pv_d         = 1'b0;
    pidx_d       = pidx_q;
    in_run_d     = in_run_q;
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    have_d       = have_q;
    pick_start_d = pick_start_q;
    pick_len_d   = pick_len_q;
    need_d       = need_q;
    strat_d      = strat_q;
    tag_d        = tag_q;
    fill_cnt_d   = fill_cnt_q;
    rd_ok_d      = rd_ok_q;
    pend_d       = pend_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = '0;
    mem_wdata_o  = fssa_pkg::FREE_TAG;
    mem_re_o     = 1'b0;
    mem_raddr_o  = '0;

    case (state_q)
      ST_CLEAR: begin
        // Sweep the store to free after reset, one slot a cycle.
        mem_we_o    = 1'b1;
        mem_waddr_o = iss_q[AW-1:0];
        if (iss_q == CW'(SLOTS - 1)) begin
          iss_d   = '0;
          state_d = ST_IDLE;
        end else begin
          iss_d = iss_q + CW'(1);
        end
      end

      ST_IDLE: begin
        if (req_fire) begin
          pend_d     = '0;
          need_d     = req.data.request_size;
          strat_d    = req.data.strategy;
          tag_d      = req.data.tag_value;
          rd_ok_d    = addr_ok;
          have_d     = 1'b0;
          case (req.data.kind)
            fssa_pkg::KIND_PRESET: begin
              mem_we_o    = addr_ok;
              mem_waddr_o = AW'(req.data.slot_address);
              mem_wdata_o = req.data.tag_value;
              state_d     = ST_DONE;
            end
            fssa_pkg::KIND_READ: begin
              mem_re_o    = addr_ok;
              mem_raddr_o = AW'(req.data.slot_address);
              state_d     = ST_READ;
            end
            fssa_pkg::KIND_ALLOC: begin
              if (req.data.request_size == 8'd0) begin
                pend_d.status = fssa_pkg::STATUS_NOSPACE;
                state_d       = ST_DONE;
              end else begin
                iss_d      = '0;
                in_run_d   = 1'b0;
                fill_cnt_d = '0;
                state_d    = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_READ: begin
        pend_d.read_tag = rd_ok_q ? mem_rdata_i : 8'd0;
        state_d         = ST_DONE;
      end

      ST_SCAN: begin
        // Issue one read a cycle; the slot read last cycle is examined now.
        if (iss_q < CW'(SLOTS)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = iss_q[AW-1:0];
          iss_d       = iss_q + CW'(1);
          pv_d        = 1'b1;
          pidx_d      = iss_q;
        end
        if (pv_q) begin
          in_run_d    = slot_free;
          run_start_d = new_start;
          run_len_d   = new_len;
          if (cand_take) begin
            have_d       = 1'b1;
            pick_start_d = cand_start;
            pick_len_d   = cand_len;
          end
          if (slot_last) begin
            state_d = ST_FILL;
          end
        end
      end

      ST_FILL: begin
        // Fill the chosen hole from its start, one slot a cycle; with no hole, report no space.
        if (!have_q) begin
          pend_d.status = fssa_pkg::STATUS_NOSPACE;
          state_d       = ST_DONE;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pick_start_q + AW'(fill_cnt_q);
          mem_wdata_o = tag_q;
          fill_cnt_d  = fill_cnt_q + 8'd1;
          if (fill_cnt_q == (need_q - 8'd1)) begin
            pend_d.status       = fssa_pkg::STATUS_DONE;
            pend_d.placed_start = 7'(pick_start_q);
            state_d             = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      iss_q    <= '0;
      pv_q     <= 1'b0;
      in_run_q <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      pv_q     <= pv_d;
      in_run_q <= in_run_d;
      have_q   <= have_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pidx_q       <= pidx_d;
    run_start_q  <= run_start_d;
    run_len_q    <= run_len_d;
    pick_start_q <= pick_start_d;
    pick_len_q   <= pick_len_d;
    need_q       <= need_d;
    strat_q      <= strat_d;
    tag_q        <= tag_d;
    fill_cnt_q   <= fill_cnt_d;
    rd_ok_q      <= rd_ok_d;
    pend_q       <= pend_d;
  end

  // A chosen hole always holds the whole request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> (GW'(pick_len_q) >= GW'(need_q)))
    else $error("chosen hole is shorter than the request");

  // The scan only reads; nothing is written while holes are searched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !mem_we_o)
    else $error("store written during the hole scan");

  // A fill never runs past the end of the chosen hole.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FILL) && have_q) |-> (CW'(fill_cnt_q) < pick_len_q))
    else $error("fill ran past the chosen hole");

  // One item at a time: after an accept the request side is closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req.ready)
    else $error("second item accepted while one is in work");

endmodule

// ----- rtl/fit_strategy_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// fit_strategy_slot_allocator
// Row of slot tags with preset, read and first/best/worst fit allocation.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                                            | Item
//  req_i   | in  | kind, slot_address, tag_value, request_size, strat | one request
//  rsp_o   | out | status, placed_start, read_tag                     | one result
//
//  After reset the store is swept to free, one slot a cycle, with req_i.ready
//  low. A preset writes the store when it is accepted; a read waits in ST_READ
//  for the registered store data. An allocation scans every slot through the
//  single read port and then fills through the write port.
//  One item is in work at a time; the result register lets the next item be
//  accepted while a result waits on a stalled rsp_o.
// ----------------------------------------------------------------------------
module fit_strategy_slot_allocator #(
  parameter int SLOTS = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fssa_req_if.sink  req_i,
  fssa_rsp_if.source rsp_o
);

  localparam int AW = $clog2(SLOTS);

  logic           res_valid;
  fssa_pkg::rsp_t res_data;
  logic           res_ready;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_rdata;
  logic           out_valid_q;
  fssa_pkg::rsp_t out_q;

  fssa_ctrl #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .res_valid_o (res_valid),
    .res_o       (res_data),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fssa_mem #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res_data;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fit-strategy slot allocator. A directed opening
// walks the edge cases of preset, read and first/best/worst fit allocation.
// A long random mix follows: allocations of mostly small runs, freed runs,
// fragmenting presets, reads and the odd unused kind. A local copy of the slot
// row predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          SLOTS        = 128;
  localparam int          ITEM_TARGET  = 1250;
  localparam int          CYCLE_LIMIT  = 1500000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          HOLD_CYCLES  = 1500;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam logic [1:0]  STRAT_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;

  fssa_req_if req_ch ();
  fssa_rsp_if rsp_ch ();

  fit_strategy_slot_allocator #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  // Local copy of the slot row and the bench bookkeeping.
  logic [7:0]     slot_model [SLOTS];
  fssa_pkg::req_t request_backlog [$];
  fssa_pkg::rsp_t pending_answers [$];
  logic           req_taken;
  logic           rsp_taken;
  int             items_queued;
  int             items_accepted;
  int             results_seen;
  int             fault_count;
  int             cycle_count;
  int             n_placed;
  int             n_nospace;
  int             n_reads;
  int             n_presets;
  int             n_best;
  int             n_worst;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Work out the answer to one item and apply it to the local slot row.
  function automatic fssa_pkg::rsp_t slot_outcome(input fssa_pkg::req_t r);
    fssa_pkg::rsp_t o;
    int   pos;
    int   run_start;
    int   run_len;
    int   pick_start;
    int   pick_len;
    bit   have;
    o = '0;
    case (r.kind)
      fssa_pkg::KIND_PRESET: begin
        slot_model[r.slot_address] = r.tag_value;
        n_presets++;
      end
      fssa_pkg::KIND_READ: begin
        o.read_tag = slot_model[r.slot_address];
        n_reads++;
      end
      fssa_pkg::KIND_ALLOC: begin
        have       = 1'b0;
        pick_start = 0;
        pick_len   = 0;
        pos        = 0;
        if (r.request_size != 8'd0) begin
          // Walk the holes; first fit stops at the first one that fits.
          while (pos < SLOTS) begin
            if (slot_model[pos] != fssa_pkg::FREE_TAG) begin
              pos++;
            end else begin
              run_start = pos;
              while (pos < SLOTS && slot_model[pos] == fssa_pkg::FREE_TAG) pos++;
              run_len = pos - run_start;
              if (run_len >= int'(r.request_size)) begin
                if (!have) begin
                  have       = 1'b1;
                  pick_start = run_start;
                  pick_len   = run_len;
                  if (r.strategy != fssa_pkg::STRAT_BEST &&
                      r.strategy != fssa_pkg::STRAT_WORST) break;
                end else if (r.strategy == fssa_pkg::STRAT_BEST &&
                             run_len < pick_len) begin
                  pick_start = run_start;
                  pick_len   = run_len;
                end else if (r.strategy == fssa_pkg::STRAT_WORST &&
                             run_len > pick_len) begin
                  pick_start = run_start;
                  pick_len   = run_len;
                end
              end
            end
          end
        end
        if (have) begin
          for (int j = 0; j < int'(r.request_size) && pick_start + j < SLOTS; j++) begin
            slot_model[pick_start + j] = r.tag_value;
          end
          o.status       = fssa_pkg::STATUS_DONE;
          o.placed_start = pick_start[6:0];
          n_placed++;
          if (r.strategy == fssa_pkg::STRAT_BEST) n_best++;
          if (r.strategy == fssa_pkg::STRAT_WORST) n_worst++;
        end else begin
          o.status = fssa_pkg::STATUS_NOSPACE;
          n_nospace++;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Append one item to the backlog; the unused kind does not count.
  task automatic queue_item(input logic [1:0] kind, input logic [6:0] addr,
                            input logic [7:0] tag, input logic [7:0] size,
                            input logic [1:0] strat);
    fssa_pkg::req_t r;
    r.kind         = kind;
    r.slot_address = addr;
    r.tag_value    = tag;
    r.request_size = size;
    r.strategy     = strat;
    request_backlog.push_back(r);
    if (kind != KIND_UNUSED) items_queued++;
  endtask

  // Random filler for the fields an item does not use.
  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Sender: offers backlog items with a random gap after each accepted one.
  int req_gap;
  bit req_steady;
  always @(negedge clk_i) begin
    logic offer;
    offer = req_ch.valid;
    if (rst_ni) begin
      if (req_taken) begin
        offer = 1'b0;
        if ($urandom_range(0, 31) == 0) req_steady = !req_steady;
        req_gap = req_steady ? 0 : $urandom_range(0, 8);
      end
      if (!offer) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (request_backlog.size() > 0) begin
          req_ch.data <= request_backlog.pop_front();
          offer = 1'b1;
        end
      end
      req_ch.valid <= offer;
    end
  end

  // Receiver: stalls each waiting result for a random count, and twice holds
  // off for a long stretch so that the block backs up into its input.
  int  rsp_wait;
  int  hold_left;
  bit  rsp_steady;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_taken) begin
        if ($urandom_range(0, 31) == 0) rsp_steady = !rsp_steady;
        rsp_wait = rsp_steady ? 0 : $urandom_range(0, 8);
        if (results_seen == 400 || results_seen == 1000) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_wait > 0 && rsp_ch.valid) begin
        rsp_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: checks each accepted result, then predicts each accepted item.
  always @(posedge clk_i) begin
    fssa_pkg::rsp_t want;
    req_taken <= rst_ni && req_ch.valid && req_ch.ready;
    rsp_taken <= rst_ni && rsp_ch.valid && rsp_ch.ready;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (pending_answers.size() == 0) begin
          $display("%0t: result with nothing expected: got %p", $time, rsp_ch.data);
          fault_count++;
        end else begin
          want = pending_answers.pop_front();
          if (rsp_ch.data.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, rsp_ch.data.status);
            fault_count++;
          end
          if (rsp_ch.data.placed_start !== want.placed_start) begin
            $display("%0t: placed_start mismatch: expected %0d, actual %0d",
                     $time, want.placed_start, rsp_ch.data.placed_start);
            fault_count++;
          end
          if (rsp_ch.data.read_tag !== want.read_tag) begin
            $display("%0t: read_tag mismatch: expected 0x%02h, actual 0x%02h",
                     $time, want.read_tag, rsp_ch.data.read_tag);
            fault_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        items_accepted++;
        pending_answers.push_back(slot_outcome(req_ch.data));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int total;
    int pick;
    int base;
    int span;
    int sel;
    logic [7:0] size;
    rst_ni       = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    req_taken    = 1'b0;
    rsp_taken    = 1'b0;
    for (int k = 0; k < SLOTS; k++) slot_model[k] = fssa_pkg::FREE_TAG;

    // Directed opening: empty row, size limits, a full fill, then a few
    // hand-made holes to tell the three strategies apart.
    queue_item(fssa_pkg::KIND_READ, 7'd0, 8'h00, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_READ, 7'd127, 8'hFF, 8'hFF, STRAT_UNUSED);
    queue_item(fssa_pkg::KIND_ALLOC, 7'd0, 8'h11, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_ALLOC, 7'd0, 8'h22, 8'd129, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_ALLOC, 7'd127, 8'h33, 8'd255, fssa_pkg::STRAT_WORST);
    queue_item(fssa_pkg::KIND_ALLOC, 7'd0, 8'hA5, 8'd128, fssa_pkg::STRAT_BEST);
    queue_item(fssa_pkg::KIND_READ, 7'd64, 8'h00, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_PRESET, 7'd5, fssa_pkg::FREE_TAG, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_PRESET, 7'd20, fssa_pkg::FREE_TAG, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_PRESET, 7'd21, fssa_pkg::FREE_TAG, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_PRESET, 7'd40, fssa_pkg::FREE_TAG, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_PRESET, 7'd41, fssa_pkg::FREE_TAG, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_PRESET, 7'd42, fssa_pkg::FREE_TAG, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_ALLOC, 7'd0, 8'hB1, 8'd2, fssa_pkg::STRAT_BEST);
    queue_item(fssa_pkg::KIND_ALLOC, 7'd0, 8'hB2, 8'd1, fssa_pkg::STRAT_WORST);
    queue_item(fssa_pkg::KIND_ALLOC, 7'd0, 8'hB3, 8'd1, STRAT_UNUSED);
    queue_item(fssa_pkg::KIND_ALLOC, 7'd0, 8'hB4, 8'd3, fssa_pkg::STRAT_FIRST);
    // Filling with the free code succeeds but leaves the run free.
    queue_item(fssa_pkg::KIND_ALLOC, 7'd0, fssa_pkg::FREE_TAG, 8'd2, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_READ, 7'd41, 8'h00, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(KIND_UNUSED, 7'h7F, 8'hFF, 8'hFF, STRAT_UNUSED);
    queue_item(fssa_pkg::KIND_PRESET, 7'd127, 8'hFF, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_READ, 7'd127, 8'h00, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_PRESET, 7'd0, 8'h00, 8'd0, fssa_pkg::STRAT_FIRST);
    queue_item(fssa_pkg::KIND_READ, 7'd0, 8'h00, 8'd0, fssa_pkg::STRAT_FIRST);

    // Random mix. Freed runs and fragmenting presets keep the row full of
    // holes of many sizes, so allocations see all three strategies at work.
    while (items_queued < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        size = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, 128))
                                           : 8'($urandom_range(1, 16));
        queue_item(fssa_pkg::KIND_ALLOC, 7'($urandom_range(0, 127)),
                   ($urandom_range(0, 15) == 0) ? fssa_pkg::FREE_TAG : any_byte(),
                   size, 2'($urandom_range(0, 3)));
      end else if (pick < 40) begin
        // Zero, full-row and oversized requests.
        sel = $urandom_range(0, 2);
        size = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd128 : 8'($urandom_range(129, 255));
        queue_item(fssa_pkg::KIND_ALLOC, 7'($urandom_range(0, 127)), any_byte(), size,
                   2'($urandom_range(0, 3)));
      end else if (pick < 60) begin
        // Free a contiguous run.
        base = $urandom_range(0, SLOTS - 1);
        span = $urandom_range(1, 12);
        for (int k = base; k < base + span && k < SLOTS; k++) begin
          queue_item(fssa_pkg::KIND_PRESET, 7'(k), fssa_pkg::FREE_TAG, any_byte(),
                     2'($urandom_range(0, 3)));
        end
      end else if (pick < 72) begin
        queue_item(fssa_pkg::KIND_PRESET, 7'($urandom_range(0, 127)),
                   ($urandom_range(0, 7) == 0) ? fssa_pkg::FREE_TAG : any_byte(),
                   any_byte(), 2'($urandom_range(0, 3)));
      end else if (pick < 92) begin
        queue_item(fssa_pkg::KIND_READ, 7'($urandom_range(0, 127)), any_byte(),
                   any_byte(), 2'($urandom_range(0, 3)));
      end else if (pick < 97) begin
        // Chop a stretch into small holes: every other slot taken.
        base = $urandom_range(0, SLOTS - 1);
        for (int k = base; k < base + 16 && k < SLOTS; k++) begin
          queue_item(fssa_pkg::KIND_PRESET, 7'(k),
                     (k % 2 == 0) ? 8'hC3 : fssa_pkg::FREE_TAG,
                     8'd0, fssa_pkg::STRAT_FIRST);
        end
      end else if (pick < 99) begin
        queue_item(KIND_UNUSED, 7'($urandom_range(0, 127)), any_byte(), any_byte(),
                   2'($urandom_range(0, 3)));
      end else begin
        // Occasionally clear the whole row.
        for (int k = 0; k < SLOTS; k++) begin
          queue_item(fssa_pkg::KIND_PRESET, 7'(k), fssa_pkg::FREE_TAG, 8'd0,
                     fssa_pkg::STRAT_FIRST);
        end
      end
    end
    total = request_backlog.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every item to go in and every result to come back.
    wait (items_accepted == total);
    wait (pending_answers.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d items: %0d runs placed (%0d best fit, %0d worst fit),",
             items_accepted, n_placed, n_best, n_worst);
    $display("%0d requests without space, %0d reads and %0d presets, %0d results checked.",
             n_nospace, n_reads, n_presets, results_seen);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
